// File: rtl/stable_min_priority_queue_assert.svh
// assertion macros for the stable minimum priority queue
`ifndef STABLE_MIN_PRIORITY_QUEUE_ASSERT_SVH
`define STABLE_MIN_PRIORITY_QUEUE_ASSERT_SVH

// clocked check, disabled while reset is held
`define SMPQ_ASSERT(name, clk, rst_n, prop, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// clocked check that also holds during reset
`define SMPQ_ASSERT_ALWAYS(name, clk, prop, msg) \
  name: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: rtl/smpq_pkg.sv
// shared types and constants of the stable minimum priority queue
`default_nettype none

package smpq_pkg;

  localparam int unsigned SMPQ_CAPACITY = 32;
  localparam int unsigned SMPQ_KEY_BITS = 16;
  localparam int unsigned SMPQ_TAG_BITS = 16;
  localparam int unsigned SMPQ_FLUSH_BITS = 6;

  typedef enum logic [1:0] {
    OP_ADD   = 2'd0,
    OP_POP   = 2'd1,
    OP_FLUSH = 2'd2,
    OP_STOP  = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_EMPTY   = 2'd1,
    ST_STOPPED = 2'd2,
    ST_FULL    = 2'd3
  } status_e;

  // command broadcast to every cell of the chain
  typedef struct packed {
    logic insert;
    logic pop;
    logic flush;
  } cell_cmd_t;

endpackage

`default_nettype wire

// File: rtl/stable_min_priority_queue.sv
// top level of the stable minimum priority queue: sorted cell chain and result register
//
// Usage: one input beat carries an operation (add, pop lowest, flush, stop)
// with a key and a tag; each input beat yields exactly one output beat with
// status, got_job, out_tag, flushed_count and all_done.
// Entries sit in a row of CAPACITY cells kept sorted by key, equal keys in
// arrival order, the lowest at the head cell. An add slides the larger
// entries one cell toward the tail; a pop takes the head and slides all
// entries one cell toward the head; a flush clears every cell at once.
// Timing: the result is written into the output register as the input
// beat is accepted. Throughput: one item per cycle while out_ready_i is high,
// set by the update of the whole cell row at once and the one-entry output register.
// Stall: while a result waits and out_ready_i is low, in_ready_o is low;
// in_ready_o rises again in the cycle the result is taken.
// Reset: all cells empty, count zero, busy and stopped clear, no result
// pending. No clearing pass is needed.
`default_nettype none

`include "stable_min_priority_queue_assert.svh"

module stable_min_priority_queue #(
  parameter int unsigned CAPACITY = smpq_pkg::SMPQ_CAPACITY,
  parameter int unsigned KEY_BITS = smpq_pkg::SMPQ_KEY_BITS,
  parameter int unsigned TAG_BITS = smpq_pkg::SMPQ_TAG_BITS
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 in_valid_i,
  output logic                      in_ready_o,
  input  wire logic [1:0]           op_i,
  input  wire logic [KEY_BITS-1:0]  job_key_i,
  input  wire logic [TAG_BITS-1:0]  job_tag_i,
  output logic                      out_valid_o,
  input  wire logic                 out_ready_i,
  output logic [1:0]                status_o,
  output logic                      got_job_o,
  output logic [TAG_BITS-1:0]       out_tag_o,
  output logic [smpq_pkg::SMPQ_FLUSH_BITS-1:0] flushed_count_o,
  output logic                      all_done_o
);
  import smpq_pkg::*;

  localparam int unsigned CntW = $clog2(CAPACITY + 1);

  logic                accept;
  logic                full;
  logic [CntW-1:0]     cnt_q, cnt_d;
  logic                busy_q, busy_d;
  logic                stopped_q, stopped_d;
  cell_cmd_t           cmd;
  status_e             status;
  logic                got;
  logic [TAG_BITS-1:0] otag;
  logic [SMPQ_FLUSH_BITS-1:0] flushed;

  logic                out_valid_q;
  logic [1:0]          status_q;
  logic                got_q;
  logic [TAG_BITS-1:0] tag_q;
  logic [SMPQ_FLUSH_BITS-1:0] flushed_q;
  logic                done_q;

  logic                cell_valid [CAPACITY];
  logic [KEY_BITS-1:0] cell_key   [CAPACITY];
  logic [TAG_BITS-1:0] cell_tag   [CAPACITY];
  logic                cell_gt    [CAPACITY];

  // input beat taken whenever the result register is free or draining
  assign in_ready_o = !out_valid_q || out_ready_i;
  assign accept     = in_valid_i && in_ready_o;
  assign full       = (cnt_q == CntW'(CAPACITY));

  // operation decode and result fields
  always_comb begin
    cmd       = '0;
    status    = ST_OK;
    got       = 1'b0;
    otag      = '0;
    flushed   = '0;
    cnt_d     = cnt_q;
    busy_d    = busy_q;
    stopped_d = stopped_q;
    if (accept) begin
      case (op_e'(op_i))
        OP_ADD: begin
          if (full) begin
            status = ST_FULL;
          end else begin
            cmd.insert = 1'b1;
            cnt_d      = cnt_q + CntW'(1);
          end
        end
        OP_POP: begin
          busy_d = 1'b0;
          if (stopped_q) begin
            status = ST_STOPPED;
          end else if (cnt_q == '0) begin
            status = ST_EMPTY;
          end else begin
            cmd.pop = 1'b1;
            got     = 1'b1;
            otag    = cell_tag[0];
            cnt_d   = cnt_q - CntW'(1);
            busy_d  = 1'b1;
          end
        end
        OP_FLUSH: begin
          cmd.flush = 1'b1;
          flushed   = SMPQ_FLUSH_BITS'(cnt_q);
          cnt_d     = '0;
        end
        OP_STOP: begin
          stopped_d = 1'b1;
        end
        default: begin
          stopped_d = stopped_q;
        end
      endcase
    end
  end

  // sorted chain of cells, head at index 0
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic                prev_valid;
    logic [KEY_BITS-1:0] prev_key;
    logic [TAG_BITS-1:0] prev_tag;
    logic                prev_gt;
    logic                next_valid;
    logic [KEY_BITS-1:0] next_key;
    logic [TAG_BITS-1:0] next_tag;

    if (i == 0) begin : g_head
      assign prev_valid = 1'b0;
      assign prev_key   = '0;
      assign prev_tag   = '0;
      assign prev_gt    = 1'b0;
    end else begin : g_body
      assign prev_valid = cell_valid[i-1];
      assign prev_key   = cell_key[i-1];
      assign prev_tag   = cell_tag[i-1];
      assign prev_gt    = cell_gt[i-1];
    end

    if (i == CAPACITY - 1) begin : g_tail
      assign next_valid = 1'b0;
      assign next_key   = '0;
      assign next_tag   = '0;
    end else begin : g_mid
      assign next_valid = cell_valid[i+1];
      assign next_key   = cell_key[i+1];
      assign next_tag   = cell_tag[i+1];
    end

    smpq_cell #(
      .KEY_BITS (KEY_BITS),
      .TAG_BITS (TAG_BITS)
    ) u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .cmd_i        (cmd),
      .new_key_i    (job_key_i),
      .new_tag_i    (job_tag_i),
      .prev_valid_i (prev_valid),
      .prev_key_i   (prev_key),
      .prev_tag_i   (prev_tag),
      .prev_gt_i    (prev_gt),
      .next_valid_i (next_valid),
      .next_key_i   (next_key),
      .next_tag_i   (next_tag),
      .valid_o      (cell_valid[i]),
      .key_o        (cell_key[i]),
      .tag_o        (cell_tag[i]),
      .gt_o         (cell_gt[i])
    );
  end

  // control state and result valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q       <= '0;
      busy_q      <= 1'b0;
      stopped_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      cnt_q     <= cnt_d;
      busy_q    <= busy_d;
      stopped_q <= stopped_d;
      if (accept) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // result payload register
  always_ff @(posedge clk_i) begin
    if (accept) begin
      status_q  <= status;
      got_q     <= got;
      tag_q     <= otag;
      flushed_q <= flushed;
      done_q    <= (cnt_d == '0) && !busy_d;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign status_o        = status_q;
  assign got_job_o       = got_q;
  assign out_tag_o       = tag_q;
  assign flushed_count_o = flushed_q;
  assign all_done_o      = done_q;

  // checks
  `SMPQ_ASSERT_ALWAYS(a_reset_idle, clk_i, !rst_ni |=> !out_valid_q, "result valid after reset")
  `SMPQ_ASSERT(a_cnt_range, clk_i, rst_ni, cnt_q <= CntW'(CAPACITY), "count above capacity")
  `SMPQ_ASSERT(a_head_valid, clk_i, rst_ni,
               cell_valid[0] == (cnt_q != '0), "head cell and count disagree")
  `SMPQ_ASSERT(a_tail_valid, clk_i, rst_ni,
               cell_valid[CAPACITY-1] == full, "tail cell and full disagree")
  `SMPQ_ASSERT(a_pop_count, clk_i, rst_ni,
               cmd.pop |=> (cnt_q == $past(cnt_q) - CntW'(1)), "pop did not shrink count")

endmodule

`default_nettype wire

// File: rtl/smpq_cell.sv
// one slot of the sorted chain: holds an entry and trades with its neighbors
`default_nettype none

module smpq_cell #(
  parameter int unsigned KEY_BITS = 16,
  parameter int unsigned TAG_BITS = 16
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire smpq_pkg::cell_cmd_t   cmd_i,
  input  wire logic [KEY_BITS-1:0]   new_key_i,
  input  wire logic [TAG_BITS-1:0]   new_tag_i,
  input  wire logic                  prev_valid_i,
  input  wire logic [KEY_BITS-1:0]   prev_key_i,
  input  wire logic [TAG_BITS-1:0]   prev_tag_i,
  input  wire logic                  prev_gt_i,
  input  wire logic                  next_valid_i,
  input  wire logic [KEY_BITS-1:0]   next_key_i,
  input  wire logic [TAG_BITS-1:0]   next_tag_i,
  output logic                       valid_o,
  output logic [KEY_BITS-1:0]        key_o,
  output logic [TAG_BITS-1:0]        tag_o,
  output logic                       gt_o
);
  import smpq_pkg::*;

  logic                valid_q, valid_d;
  logic [KEY_BITS-1:0] key_q, key_d;
  logic [TAG_BITS-1:0] tag_q, tag_d;

  // slot lies behind the new entry: empty, or strictly larger key
  assign gt_o = !valid_q || (key_q > new_key_i);

  // next slot contents
  always_comb begin
    valid_d = valid_q;
    key_d   = key_q;
    tag_d   = tag_q;
    if (cmd_i.flush) begin
      valid_d = 1'b0;
    end else if (cmd_i.pop) begin
      valid_d = next_valid_i;
      key_d   = next_key_i;
      tag_d   = next_tag_i;
    end else if (cmd_i.insert && gt_o) begin
      if (prev_gt_i) begin
        valid_d = prev_valid_i;
        key_d   = prev_key_i;
        tag_d   = prev_tag_i;
      end else begin
        valid_d = 1'b1;
        key_d   = new_key_i;
        tag_d   = new_tag_i;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // payload needs no reset
  always_ff @(posedge clk_i) begin
    key_q <= key_d;
    tag_q <= tag_d;
  end

  assign valid_o = valid_q;
  assign key_o   = key_q;
  assign tag_o   = tag_q;

endmodule

`default_nettype wire
